### rtl/six_step_commutation_ramp_macros.svh
`ifndef SIX_STEP_COMMUTATION_RAMP_MACROS_SVH
`define SIX_STEP_COMMUTATION_RAMP_MACROS_SVH

// same-cycle implication on the block clock
`define SCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on the block clock
`define SCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/scr_pkg.sv
`timescale 1ns / 1ps
package scr_pkg;

    localparam int CFG_COUNT_W = 16;
    localparam int CFG_IV_W    = 8;
    localparam int DRIVE_W     = 2;
    localparam int STEP_W      = 3;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    localparam int DEF_COUNT_WIDTH    = 16;
    localparam int DEF_INTERVAL_WIDTH = 8;

    localparam logic [CFG_COUNT_W-1:0] RST_TOP_COUNT   = 16'd900;
    localparam logic [CFG_COUNT_W-1:0] RST_START_COUNT = 16'd10;
    localparam logic [CFG_IV_W-1:0]    RST_IV_START    = 8'd8;
    localparam logic [CFG_IV_W-1:0]    RST_IV_TARGET   = 8'd1;
    localparam logic [CFG_COUNT_W-1:0] RST_PWM_HIGH    = 16'd0;
    localparam logic [CFG_COUNT_W-1:0] RST_ALIGN_TICKS = 16'd300;

    localparam logic [STEP_W-1:0] STEP_FIRST = 3'd0;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd5;

    typedef enum logic [2:0] {
        REG_TOP_COUNT       = 3'd0,
        REG_START_COUNT     = 3'd1,
        REG_INTERVAL_START  = 3'd2,
        REG_INTERVAL_TARGET = 3'd3,
        REG_PWM_HIGH        = 3'd4,
        REG_ALIGN_TICKS     = 3'd5
    } t_reg_idx;

    typedef enum logic [DRIVE_W-1:0] {
        DRV_FLOAT = 2'd0,
        DRV_LOW   = 2'd1,
        DRV_HIGH  = 2'd2
    } t_drive;

    typedef struct packed {
        t_drive c;
        t_drive b;
        t_drive a;
    } t_pattern;

    typedef struct packed {
        logic [CFG_COUNT_W-1:0] top_count;
        logic [CFG_COUNT_W-1:0] start_count;
        logic [CFG_IV_W-1:0]    interval_start;
        logic [CFG_IV_W-1:0]    interval_target;
        logic [CFG_COUNT_W-1:0] pwm_high;
        logic [CFG_COUNT_W-1:0] align_ticks;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic tick;
        logic setup;
        logic mul;
        logic div;
        logic fix;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic begin_iv;
        logic trivial;
        logic div_last;
        logic out_blocked;
    } t_dp_status;

    localparam t_pattern ALIGN_PATTERN = '{a: DRV_FLOAT, b: DRV_LOW, c: DRV_HIGH};

    function automatic t_pattern step_pattern(input logic [STEP_W-1:0] idx);
        t_pattern p;
        case (idx)
            3'd0:    p = '{a: DRV_HIGH,  b: DRV_LOW,   c: DRV_FLOAT};
            3'd1:    p = '{a: DRV_HIGH,  b: DRV_FLOAT, c: DRV_LOW};
            3'd2:    p = '{a: DRV_FLOAT, b: DRV_HIGH,  c: DRV_LOW};
            3'd3:    p = '{a: DRV_LOW,   b: DRV_HIGH,  c: DRV_FLOAT};
            3'd4:    p = '{a: DRV_LOW,   b: DRV_FLOAT, c: DRV_HIGH};
            3'd5:    p = '{a: DRV_FLOAT, b: DRV_LOW,   c: DRV_HIGH};
            default: p = '{a: DRV_HIGH,  b: DRV_LOW,   c: DRV_FLOAT};
        endcase
        return p;
    endfunction

endpackage

### rtl/six_step_commutation_ramp.sv
`timescale 1ns / 1ps
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------------------
// tick in  | i_in_valid / o_in_stall    | i_restart
// step out | o_out_valid / i_out_stall  | o_phase_*_drive, o_phase_*_compare,
//          |                            | o_commutated, o_marker, o_step_index,
//          |                            | o_ramp_position, o_aligning
// config   | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// A tick that starts no interval goes from IDLE straight to EMIT; one that starts an
// interval with a flat length passes SETUP first; one on the ramp slope also passes MUL,
// DIV and FIX, where the restoring divider makes one quotient bit per cycle.
// Reset (i_rst_n low, synchronous) enters alignment with all config registers at defaults.
// o_in_stall is high while a tick is in work; a held output word delays only the next.
module six_step_commutation_ramp
    import scr_pkg::*;
#(
    parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH,
    parameter int INTERVAL_WIDTH = DEF_INTERVAL_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_restart,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [DRIVE_W-1:0]     o_phase_a_drive,
    output logic [DRIVE_W-1:0]     o_phase_b_drive,
    output logic [DRIVE_W-1:0]     o_phase_c_drive,
    output logic [CFG_COUNT_W-1:0] o_phase_a_compare,
    output logic [CFG_COUNT_W-1:0] o_phase_b_compare,
    output logic [CFG_COUNT_W-1:0] o_phase_c_compare,
    output logic                   o_commutated,
    output logic                   o_marker,
    output logic [STEP_W-1:0]      o_step_index,
    output logic [CFG_COUNT_W-1:0] o_ramp_position,
    output logic                   o_aligning,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    t_cfg       w_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    scr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    scr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    scr_datapath #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .INTERVAL_WIDTH (INTERVAL_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (w_cfg),
        .i_restart         (i_restart),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_phase_a_drive   (o_phase_a_drive),
        .o_phase_b_drive   (o_phase_b_drive),
        .o_phase_c_drive   (o_phase_c_drive),
        .o_phase_a_compare (o_phase_a_compare),
        .o_phase_b_compare (o_phase_b_compare),
        .o_phase_c_compare (o_phase_c_compare),
        .o_commutated      (o_commutated),
        .o_marker          (o_marker),
        .o_step_index      (o_step_index),
        .o_ramp_position   (o_ramp_position),
        .o_aligning        (o_aligning)
    );

endmodule

### rtl/scr_regs.sv
`timescale 1ns / 1ps
module scr_regs
    import scr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.top_count       <= RST_TOP_COUNT;
            r_cfg.start_count     <= RST_START_COUNT;
            r_cfg.interval_start  <= RST_IV_START;
            r_cfg.interval_target <= RST_IV_TARGET;
            r_cfg.pwm_high        <= RST_PWM_HIGH;
            r_cfg.align_ticks     <= RST_ALIGN_TICKS;
        end else if (w_wr) begin
            case (w_idx)
                REG_TOP_COUNT:       r_cfg.top_count       <= pwdata[CFG_COUNT_W-1:0];
                REG_START_COUNT:     r_cfg.start_count     <= pwdata[CFG_COUNT_W-1:0];
                REG_INTERVAL_START:  r_cfg.interval_start  <= pwdata[CFG_IV_W-1:0];
                REG_INTERVAL_TARGET: r_cfg.interval_target <= pwdata[CFG_IV_W-1:0];
                REG_PWM_HIGH:        r_cfg.pwm_high        <= pwdata[CFG_COUNT_W-1:0];
                REG_ALIGN_TICKS:     r_cfg.align_ticks     <= pwdata[CFG_COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TOP_COUNT:       prdata = PDATA_W'(r_cfg.top_count);
            REG_START_COUNT:     prdata = PDATA_W'(r_cfg.start_count);
            REG_INTERVAL_START:  prdata = PDATA_W'(r_cfg.interval_start);
            REG_INTERVAL_TARGET: prdata = PDATA_W'(r_cfg.interval_target);
            REG_PWM_HIGH:        prdata = PDATA_W'(r_cfg.pwm_high);
            REG_ALIGN_TICKS:     prdata = PDATA_W'(r_cfg.align_ticks);
            default:             prdata = '0;
        endcase
    end

endmodule

### rtl/scr_ctrl.sv
`timescale 1ns / 1ps
module scr_ctrl
    import scr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.tick = 1'b1;
                    n_state    = i_status.begin_iv ? ST_SETUP : ST_EMIT;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_status.trivial ? ST_EMIT : ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_status.out_blocked) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/scr_datapath.sv
`timescale 1ns / 1ps
module scr_datapath
    import scr_pkg::*;
#(
    parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH,
    parameter int INTERVAL_WIDTH = DEF_INTERVAL_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_restart,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [DRIVE_W-1:0]     o_phase_a_drive,
    output logic [DRIVE_W-1:0]     o_phase_b_drive,
    output logic [DRIVE_W-1:0]     o_phase_c_drive,
    output logic [CFG_COUNT_W-1:0] o_phase_a_compare,
    output logic [CFG_COUNT_W-1:0] o_phase_b_compare,
    output logic [CFG_COUNT_W-1:0] o_phase_c_compare,
    output logic                   o_commutated,
    output logic                   o_marker,
    output logic [STEP_W-1:0]      o_step_index,
    output logic [CFG_COUNT_W-1:0] o_ramp_position,
    output logic                   o_aligning
);

    localparam int CW    = COUNT_WIDTH;
    localparam int IW    = INTERVAL_WIDTH;
    localparam int N     = CW + IW;
    localparam int CNT_W = $clog2(N);

    // tick state
    logic            r_align;
    logic [CW-1:0]   r_tick;
    logic [CW-1:0]   r_ramp;
    logic [STEP_W-1:0] r_step;
    logic [IW-1:0]   r_len;
    logic            r_marker;
    t_pattern        r_pattern;
    logic            r_commut;

    // interval arithmetic
    logic [CW-1:0]   r_k;
    logic [CW-1:0]   r_d;
    logic [IW-1:0]   r_diff;
    logic            r_up;
    logic [N-1:0]    r_dvd;
    logic [CW-1:0]   r_rem;
    logic [CNT_W-1:0] r_div_cnt;

    // output word
    logic                   r_out_valid;
    t_pattern               r_out_pattern;
    logic [CFG_COUNT_W-1:0] r_out_cmp_a;
    logic [CFG_COUNT_W-1:0] r_out_cmp_b;
    logic [CFG_COUNT_W-1:0] r_out_cmp_c;
    logic                   r_out_commut;
    logic                   r_out_marker;
    logic [STEP_W-1:0]      r_out_step;
    logic [CFG_COUNT_W-1:0] r_out_ramp;
    logic                   r_out_align;

    logic [CW-1:0]     w_top;
    logic [CW-1:0]     w_start;
    logic [CW-1:0]     w_align_ticks;
    logic [IW-1:0]     w_is;
    logic [IW-1:0]     w_it;
    logic [CW-1:0]     w_pos;
    logic [CW-1:0]     w_tick_inc;
    logic              w_align_done;
    logic              w_iv_done;
    logic              w_trivial;
    logic [STEP_W-1:0] w_step;
    logic [CW:0]       w_rem_sh;
    logic              w_qbit;
    logic [IW-1:0]     w_q;
    logic [IW-1:0]     w_sum;

    assign w_top         = CW'(i_cfg.top_count);
    assign w_start       = CW'(i_cfg.start_count);
    assign w_align_ticks = CW'(i_cfg.align_ticks);
    assign w_is          = IW'(i_cfg.interval_start);
    assign w_it          = IW'(i_cfg.interval_target);
    assign w_pos         = (r_ramp > w_top) ? w_top : r_ramp;
    assign w_tick_inc    = r_tick + CW'(1);
    assign w_align_done  = r_tick >= w_align_ticks;
    assign w_iv_done     = w_tick_inc >= CW'(r_len);
    assign w_trivial     = (w_top <= w_start) || (w_pos <= w_start);
    assign w_step        = (r_step > STEP_LAST) ? STEP_FIRST : r_step;
    assign w_rem_sh      = {r_rem, r_dvd[N-1]};
    assign w_qbit        = w_rem_sh >= {1'b0, r_d};
    assign w_q           = r_dvd[IW-1:0];
    assign w_sum         = r_up ? (w_is + w_q) : (w_is - w_q);

    assign o_status.begin_iv    = !i_restart && (r_align ? w_align_done : w_iv_done);
    assign o_status.trivial     = w_trivial;
    assign o_status.div_last    = r_div_cnt == '0;
    assign o_status.out_blocked = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align   <= 1'b1;
            r_tick    <= '0;
            r_ramp    <= '0;
            r_step    <= STEP_FIRST;
            r_len     <= '0;
            r_marker  <= 1'b0;
            r_pattern <= ALIGN_PATTERN;
            r_commut  <= 1'b0;
        end else if (i_cmd.tick) begin
            r_commut <= 1'b0;
            if (i_restart) begin
                r_align   <= 1'b1;
                r_tick    <= '0;
                r_ramp    <= '0;
                r_step    <= STEP_FIRST;
                r_len     <= '0;
                r_pattern <= ALIGN_PATTERN;
            end else if (r_align) begin
                if (w_align_done) begin
                    r_align <= 1'b0;
                    r_tick  <= '0;
                    if (r_ramp < w_top) begin
                        r_ramp <= r_ramp + CW'(1);
                    end
                end else begin
                    r_tick <= w_tick_inc;
                end
            end else if (w_iv_done) begin
                r_marker  <= !r_marker;
                r_pattern <= step_pattern(w_step);
                r_step    <= (w_step == STEP_LAST) ? STEP_FIRST : w_step + STEP_W'(1);
                r_commut  <= 1'b1;
                r_tick    <= '0;
                if (r_ramp < w_top) begin
                    r_ramp <= r_ramp + CW'(1);
                end
            end else begin
                r_tick <= w_tick_inc;
            end
        end else if (i_cmd.setup && w_trivial) begin
            r_len <= (w_is == '0) ? IW'(1) : w_is;
        end else if (i_cmd.fix) begin
            r_len <= (w_sum == '0) ? IW'(1) : w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_k    <= w_pos - w_start;
            r_d    <= w_top - w_start;
            r_up   <= w_it > w_is;
            r_diff <= (w_it > w_is) ? (w_it - w_is) : (w_is - w_it);
        end
        if (i_cmd.mul) begin
            r_dvd     <= r_k * r_diff;
            r_rem     <= '0;
            r_div_cnt <= CNT_W'(N - 1);
        end else if (i_cmd.div) begin
            r_rem     <= w_qbit ? CW'(w_rem_sh - {1'b0, r_d}) : w_rem_sh[CW-1:0];
            r_dvd     <= {r_dvd[N-2:0], w_qbit};
            r_div_cnt <= r_div_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_pattern <= r_pattern;
            r_out_cmp_a   <= (r_pattern.a == DRV_HIGH) ? i_cfg.pwm_high : '0;
            r_out_cmp_b   <= (r_pattern.b == DRV_HIGH) ? i_cfg.pwm_high : '0;
            r_out_cmp_c   <= (r_pattern.c == DRV_HIGH) ? i_cfg.pwm_high : '0;
            r_out_commut  <= r_commut;
            r_out_marker  <= r_marker;
            r_out_step    <= r_step;
            r_out_ramp    <= CFG_COUNT_W'(r_ramp);
            r_out_align   <= r_align;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_phase_a_drive   = r_out_pattern.a;
    assign o_phase_b_drive   = r_out_pattern.b;
    assign o_phase_c_drive   = r_out_pattern.c;
    assign o_phase_a_compare = r_out_cmp_a;
    assign o_phase_b_compare = r_out_cmp_b;
    assign o_phase_c_compare = r_out_cmp_c;
    assign o_commutated      = r_out_commut;
    assign o_marker          = r_out_marker;
    assign o_step_index      = r_out_step;
    assign o_ramp_position   = r_out_ramp;
    assign o_aligning        = r_out_align;

endmodule

### rtl/scr_checker.sv
`timescale 1ns / 1ps
`include "six_step_commutation_ramp_macros.svh"
module scr_checker
    import scr_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [DRIVE_W-1:0]     o_phase_a_drive,
    input logic [DRIVE_W-1:0]     o_phase_b_drive,
    input logic [DRIVE_W-1:0]     o_phase_c_drive,
    input logic [CFG_COUNT_W-1:0] o_phase_a_compare,
    input logic [CFG_COUNT_W-1:0] o_phase_b_compare,
    input logic [CFG_COUNT_W-1:0] o_phase_c_compare,
    input logic                   o_commutated,
    input logic                   o_marker,
    input logic [STEP_W-1:0]      o_step_index,
    input logic [CFG_COUNT_W-1:0] o_ramp_position,
    input logic                   o_aligning
);

    `SCR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_marker) && $stable(o_step_index) && $stable(o_ramp_position), "output word changed while stalled")
    `SCR_ASSERT_NOW(a_align_quiet, o_out_valid && o_aligning, !o_commutated && o_step_index == STEP_FIRST && o_ramp_position == '0, "alignment word shows ramp activity")
    `SCR_ASSERT_NOW(a_step_range, o_out_valid, o_step_index != 3'd6 && o_step_index != 3'd7, "step index out of range")
    `SCR_ASSERT_NOW(a_cmp_gate, o_out_valid, (o_phase_a_drive == DRV_HIGH || o_phase_a_compare == '0) && (o_phase_b_drive == DRV_HIGH || o_phase_b_compare == '0) && (o_phase_c_drive == DRV_HIGH || o_phase_c_compare == '0), "compare set on a phase not driven high")

endmodule

bind six_step_commutation_ramp scr_checker u_scr_checker (.*);

### bench/six_step_commutation_ramp_tb.sv
`timescale 1ns / 1ps
module six_step_commutation_ramp_tb;
    import scr_pkg::*;

    localparam logic [2:0] REG_UNUSED  = 3'd6;
    localparam int unsigned TICK_TARGET = 750;

    typedef struct packed {
        t_drive                 a_drv;
        t_drive                 b_drv;
        t_drive                 c_drv;
        logic [CFG_COUNT_W-1:0] a_cmp;
        logic [CFG_COUNT_W-1:0] b_cmp;
        logic [CFG_COUNT_W-1:0] c_cmp;
        logic                   commutated;
        logic                   marker;
        logic [STEP_W-1:0]      step;
        logic [CFG_COUNT_W-1:0] ramp;
        logic                   aligning;
    } commutation_word_t;

    class commutation_tracker;
        t_cfg                   cfg;
        logic                   aligning;
        logic [CFG_COUNT_W-1:0] tick_count;
        logic [CFG_COUNT_W-1:0] ramp;
        logic [STEP_W-1:0]      next_step;
        logic [CFG_IV_W-1:0]    interval_len;
        logic                   marker;
        t_pattern               pattern;
        commutation_word_t      pending_words[$];
        int unsigned            mismatches;

        function new();
            cfg = '{top_count: RST_TOP_COUNT, start_count: RST_START_COUNT,
                    interval_start: RST_IV_START, interval_target: RST_IV_TARGET,
                    pwm_high: RST_PWM_HIGH, align_ticks: RST_ALIGN_TICKS};
            marker = 1'b0;
            mismatches = 0;
            realign();
        endfunction

        function void realign();
            aligning = 1'b1;
            tick_count = '0;
            ramp = '0;
            next_step = STEP_FIRST;
            interval_len = '0;
            pattern = ALIGN_PATTERN;
        endfunction

        function void set_register(logic [2:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_TOP_COUNT:       cfg.top_count = value[CFG_COUNT_W-1:0];
                REG_START_COUNT:     cfg.start_count = value[CFG_COUNT_W-1:0];
                REG_INTERVAL_START:  cfg.interval_start = value[CFG_IV_W-1:0];
                REG_INTERVAL_TARGET: cfg.interval_target = value[CFG_IV_W-1:0];
                REG_PWM_HIGH:        cfg.pwm_high = value[CFG_COUNT_W-1:0];
                REG_ALIGN_TICKS:     cfg.align_ticks = value[CFG_COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function t_pattern commutation_pattern(logic [STEP_W-1:0] idx);
            t_pattern p;
            case (idx)
                3'd0:    p = '{a: DRV_HIGH,  b: DRV_LOW,   c: DRV_FLOAT};
                3'd1:    p = '{a: DRV_HIGH,  b: DRV_FLOAT, c: DRV_LOW};
                3'd2:    p = '{a: DRV_FLOAT, b: DRV_HIGH,  c: DRV_LOW};
                3'd3:    p = '{a: DRV_LOW,   b: DRV_HIGH,  c: DRV_FLOAT};
                3'd4:    p = '{a: DRV_LOW,   b: DRV_FLOAT, c: DRV_HIGH};
                default: p = '{a: DRV_FLOAT, b: DRV_LOW,   c: DRV_HIGH};
            endcase
            return p;
        endfunction

        function logic [CFG_IV_W-1:0] ramp_interval();
            logic [CFG_COUNT_W-1:0] pos;
            logic [63:0]            k;
            logic [63:0]            d;
            logic [63:0]            delta;
            logic [CFG_IV_W-1:0]    len;
            pos = (ramp > cfg.top_count) ? cfg.top_count : ramp;
            if (cfg.top_count <= cfg.start_count || pos <= cfg.start_count) begin
                len = cfg.interval_start;
            end else begin
                k = 64'(pos - cfg.start_count);
                d = 64'(cfg.top_count - cfg.start_count);
                if (cfg.interval_start >= cfg.interval_target) begin
                    delta = k * 64'(cfg.interval_start - cfg.interval_target) / d;
                    len = cfg.interval_start - delta[CFG_IV_W-1:0];
                end else begin
                    delta = k * 64'(cfg.interval_target - cfg.interval_start) / d;
                    len = cfg.interval_start + delta[CFG_IV_W-1:0];
                end
            end
            if (len == '0) len = CFG_IV_W'(1);
            return len;
        endfunction

        function void start_interval();
            if (ramp < cfg.top_count) ramp = ramp + 1'b1;
            interval_len = ramp_interval();
            tick_count = '0;
        endfunction

        function logic [CFG_COUNT_W-1:0] compare_for(t_drive drv);
            return (drv == DRV_HIGH) ? cfg.pwm_high : '0;
        endfunction

        function void note_tick(logic restart);
            commutation_word_t w;
            logic              commutated;
            commutated = 1'b0;
            if (restart) begin
                realign();
            end else if (aligning) begin
                if (tick_count >= cfg.align_ticks) begin
                    aligning = 1'b0;
                    start_interval();
                end else begin
                    tick_count = tick_count + 1'b1;
                end
            end else begin
                tick_count = tick_count + 1'b1;
                if (tick_count >= CFG_COUNT_W'(interval_len)) begin
                    marker = ~marker;
                    if (next_step > STEP_LAST) next_step = STEP_FIRST;
                    pattern = commutation_pattern(next_step);
                    next_step = (next_step == STEP_LAST) ? STEP_FIRST : next_step + 1'b1;
                    commutated = 1'b1;
                    start_interval();
                end
            end
            w.a_drv = pattern.a;
            w.b_drv = pattern.b;
            w.c_drv = pattern.c;
            w.a_cmp = compare_for(pattern.a);
            w.b_cmp = compare_for(pattern.b);
            w.c_cmp = compare_for(pattern.c);
            w.commutated = commutated;
            w.marker = marker;
            w.step = next_step;
            w.ramp = ramp;
            w.aligning = aligning;
            pending_words.push_back(w);
        endfunction

        function void compare_field(string field, logic [CFG_COUNT_W-1:0] want,
                                    logic [CFG_COUNT_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_word(commutation_word_t got);
            commutation_word_t want;
            if (pending_words.size() == 0) begin
                $error("output word with no tick pending");
                mismatches++;
                return;
            end
            want = pending_words.pop_front();
            compare_field("phase_a_drive", want.a_drv, got.a_drv);
            compare_field("phase_b_drive", want.b_drv, got.b_drv);
            compare_field("phase_c_drive", want.c_drv, got.c_drv);
            compare_field("phase_a_compare", want.a_cmp, got.a_cmp);
            compare_field("phase_b_compare", want.b_cmp, got.b_cmp);
            compare_field("phase_c_compare", want.c_cmp, got.c_cmp);
            compare_field("commutated", want.commutated, got.commutated);
            compare_field("marker", want.marker, got.marker);
            compare_field("step_index", want.step, got.step);
            compare_field("ramp_position", want.ramp, got.ramp);
            compare_field("aligning", want.aligning, got.aligning);
        endfunction

        function int unsigned pending();
            return pending_words.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   i_restart = 1'b0;
    logic                   i_out_stall = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [DRIVE_W-1:0]     o_phase_a_drive;
    logic [DRIVE_W-1:0]     o_phase_b_drive;
    logic [DRIVE_W-1:0]     o_phase_c_drive;
    logic [CFG_COUNT_W-1:0] o_phase_a_compare;
    logic [CFG_COUNT_W-1:0] o_phase_b_compare;
    logic [CFG_COUNT_W-1:0] o_phase_c_compare;
    logic                   o_commutated;
    logic                   o_marker;
    logic [STEP_W-1:0]      o_step_index;
    logic [CFG_COUNT_W-1:0] o_ramp_position;
    logic                   o_aligning;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    commutation_tracker tracker;
    commutation_word_t  seen_word;
    int unsigned        words_seen = 0;
    int unsigned        stall_left = 0;
    int unsigned        calm_left = 0;
    int unsigned        hold_left = 0;
    bit                 long_hold_done = 1'b0;
    int unsigned        ticks_sent = 0;
    int unsigned        burst_left = 0;
    int unsigned        phase_left = 0;

    six_step_commutation_ramp u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_restart         (i_restart),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_phase_a_drive   (o_phase_a_drive),
        .o_phase_b_drive   (o_phase_b_drive),
        .o_phase_c_drive   (o_phase_c_drive),
        .o_phase_a_compare (o_phase_a_compare),
        .o_phase_b_compare (o_phase_b_compare),
        .o_phase_c_compare (o_phase_c_compare),
        .o_commutated      (o_commutated),
        .o_marker          (o_marker),
        .o_step_index      (o_step_index),
        .o_ramp_position   (o_ramp_position),
        .o_aligning        (o_aligning),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned random_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_word.a_drv = t_drive'(o_phase_a_drive);
            seen_word.b_drv = t_drive'(o_phase_b_drive);
            seen_word.c_drv = t_drive'(o_phase_c_drive);
            seen_word.a_cmp = o_phase_a_compare;
            seen_word.b_cmp = o_phase_b_compare;
            seen_word.c_cmp = o_phase_c_compare;
            seen_word.commutated = o_commutated;
            seen_word.marker = o_marker;
            seen_word.step = o_step_index;
            seen_word.ramp = o_ramp_position;
            seen_word.aligning = o_aligning;
            tracker.check_word(seen_word);
            words_seen++;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!long_hold_done && words_seen >= 300 && phase_left >= 4) begin
            // hold off long enough for the block to back up into its input
            long_hold_done = 1'b1;
            hold_left = 400;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (calm_left != 0) begin
                calm_left--;
            end else if ($urandom_range(0, 49) == 0) begin
                calm_left = $urandom_range(30, 120);
            end else begin
                stall_left = random_gap();
            end
        end
    end

    task automatic send_tick(input logic restart);
        i_in_valid <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_tick(restart);
        ticks_sent++;
    endtask

    task automatic pause_sender();
        int unsigned n;
        if (burst_left != 0) begin
            burst_left--;
            n = 0;
        end else if ($urandom_range(0, 39) == 0) begin
            burst_left = $urandom_range(20, 60);
            n = 0;
        end else begin
            n = random_gap();
        end
        if (n != 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned n, input logic [63:0] restart_mask,
                             input bit random_restarts);
        for (int unsigned i = 0; i < n; i++) begin
            phase_left = n - i;
            send_tick(restart_mask[i] || (random_restarts && $urandom_range(0, 49) == 0));
            if (i + 1 < n) pause_sender();
        end
        phase_left = 0;
        drain();
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_register(idx, value);
    endtask

    task automatic bus_idle();
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_settings(input t_cfg c);
        write_reg(REG_TOP_COUNT, 32'(c.top_count));
        write_reg(REG_START_COUNT, 32'(c.start_count));
        write_reg(REG_INTERVAL_START, {24'($urandom), c.interval_start});
        write_reg(REG_INTERVAL_TARGET, 32'(c.interval_target));
        write_reg(REG_PWM_HIGH, {16'($urandom), c.pwm_high});
        write_reg(REG_ALIGN_TICKS, 32'(c.align_ticks));
    endtask

    function automatic t_cfg random_settings();
        t_cfg c;
        c.top_count = 16'($urandom_range(1, 40));
        if ($urandom_range(0, 4) == 0) begin
            c.start_count = 16'($urandom_range(0, 60));
        end else begin
            c.start_count = 16'($urandom_range(0, c.top_count / 2));
        end
        c.interval_start = 8'($urandom_range(1, 10));
        c.interval_target = 8'($urandom_range(1, 10));
        c.pwm_high = 16'($urandom);
        c.align_ticks = 16'($urandom_range(0, 6));
        return c;
    endfunction

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_cfg        settings;
        int unsigned ph;
        bit          restart_first;
        tracker = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(3, '0, 1'b0);

        settings = '{top_count: 16'd5, start_count: 16'd1, interval_start: 8'd3,
                     interval_target: 8'd1, pwm_high: 16'hFFFF, align_ticks: 16'd1};
        apply_settings(settings);
        bus_idle();
        run_phase(16, 64'h1800, 1'b0);

        // flat ramp with a zero length, plus a write past the last register
        settings = '{top_count: 16'd2, start_count: 16'd5, interval_start: 8'd0,
                     interval_target: 8'd9, pwm_high: 16'h8001, align_ticks: 16'd0};
        apply_settings(settings);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        bus_idle();
        run_phase(5, 64'h1, 1'b0);

        ph = 0;
        while (ticks_sent < TICK_TARGET) begin
            restart_first = ($urandom_range(0, 3) == 0);
            case (ph)
                0: begin
                    settings = '{top_count: 16'hFFFF, start_count: 16'd0,
                                 interval_start: 8'd1, interval_target: 8'd255,
                                 pwm_high: 16'hFFFF, align_ticks: 16'd0};
                    restart_first = 1'b1;
                end
                1: begin
                    // drop the top below the current position when that is above one
                    settings = random_settings();
                    settings.top_count = (tracker.ramp > 1) ? tracker.ramp / 2 : 16'd1;
                    settings.start_count = '0;
                    restart_first = 1'b0;
                end
                2: begin
                    settings = '{top_count: 16'd8, start_count: 16'd0,
                                 interval_start: 8'd2, interval_target: 8'd0,
                                 pwm_high: 16'd0, align_ticks: 16'd0};
                    restart_first = 1'b1;
                end
                3: begin
                    settings = '{top_count: 16'hFFFF, start_count: 16'hFFFF,
                                 interval_start: 8'd255, interval_target: 8'd255,
                                 pwm_high: 16'd0, align_ticks: 16'hFFFF};
                    restart_first = 1'b1;
                end
                default: settings = random_settings();
            endcase
            apply_settings(settings);
            bus_idle();
            run_phase($urandom_range(15, 50), 64'(restart_first), 1'b1);
            ph++;
        end

        repeat (40) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/scr_pkg.sv
rtl/scr_regs.sv
rtl/scr_ctrl.sv
rtl/scr_datapath.sv
rtl/six_step_commutation_ramp.sv
rtl/scr_checker.sv
bench/six_step_commutation_ramp_tb.sv
